### src/spot_check_range_pool_assert.svh
`ifndef SPOT_CHECK_RANGE_POOL_ASSERT_SVH
`define SPOT_CHECK_RANGE_POOL_ASSERT_SVH
// Assertion helpers for the range pool.
`define SCRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SCRP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### src/scrp_pkg.sv
// ----------------------------------------------------------------------------
// scrp_pkg
// Shared types and constants of the spot-check range pool.
// ----------------------------------------------------------------------------
package scrp_pkg;
  localparam int unsigned POOL_DEPTH_DEF = 256;
  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_PICK    = 2'd2;
  localparam logic [1:0] ST_NOPICK  = 2'd3;
  localparam logic [1:0] CFG_THRESH  = 2'd0;
  localparam logic [1:0] CFG_TRUSTED = 2'd1;
  localparam logic [1:0] CFG_UNPROV  = 2'd2;

  typedef struct packed {
    logic start;
    logic [63:0] dividend;
  } scrp_div_req_t;
endpackage

### src/scrp_mod.sv
// ----------------------------------------------------------------------------
// scrp_mod
// Bit-serial remainder of a 64-bit value by the pool occupancy.
// ----------------------------------------------------------------------------
module scrp_mod import scrp_pkg::*; #(
  parameter int unsigned CW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  scrp_div_req_t req,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [CW-1:0] rem
);
  logic [63:0] dvd_r, dvd_nxt;
  logic [CW:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [CW:0] trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[CW-1:0], dvd_r[63]};
    if (req.start) begin
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[62:0], 1'b0};
      rem_nxt = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = busy_r && (cnt_r == 7'd63);
  assign rem  = rem_nxt[CW-1:0];
endmodule

### src/spot_check_range_pool.sv
// ----------------------------------------------------------------------------
// spot_check_range_pool
// Ring pool of work ranges with duplicate check and random spot-check pick.
// ----------------------------------------------------------------------------
// One item at a time. in_stall is high from acceptance until the result
// transfer. A remember streams the stored entries through the single memory
// read port, one per cycle, with the compare working on the registered read
// of the previous entry. A pick runs a 64-step serial remainder by the
// occupancy and then one memory read. Zero-count remembers and empty or
// missed picks go straight to the result. The pool returns to idle after
// each result transfer before the next acceptance; out_stall holds the
// result until it is taken.
module spot_check_range_pool import scrp_pkg::*; #(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [63:0] in_range_start,
  input  logic [63:0] in_range_count,
  input  logic [63:0] in_range_checksum,
  input  logic [15:0] in_worker_score,
  input  logic [15:0] in_chance_roll,
  input  logic [63:0] in_index_roll,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_pick_start,
  output logic [63:0] out_pick_count,
  output logic [63:0] out_pick_checksum,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int unsigned AW = $clog2(POOL_DEPTH);
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_DIV = 5'b00100,
    S_RD   = 5'b01000, S_OUT  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [15:0]   thr_r;
  logic [16:0]   trust_r, unprov_r;
  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [63:0]   st_r, ct_r, ck_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [191:0]  mem [POOL_DEPTH];
  logic [191:0]  rd_q;
  logic [1:0]    status_r, status_nxt;
  logic          pick_r, pick_nxt;
  logic          busy_in;
  scrp_div_req_t dreq;
  logic          ddone;
  logic [CW-1:0] drem;
  logic [16:0]   rate;
  logic          accept;

  scrp_mod #(.CW(CW)) u_mod (
    .clk(clk), .rst_n(rst_n), .req(dreq), .divisor(occ_r), .done(ddone), .rem(drem)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign rate      = (in_worker_score >= thr_r) ? trust_r : unprov_r;
  assign busy_in   = 1'b0;

  function automatic logic [AW-1:0] ring(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, base} + {1'b0, off};
    if (s >= (CW+1)'(POOL_DEPTH)) s = s - (CW+1)'(POOL_DEPTH);
    return s[AW-1:0];
  endfunction

  always_comb begin
    state_nxt  = state_r;
    oldest_nxt = oldest_r;
    occ_nxt    = occ_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    pick_nxt   = pick_r;
    wr_en      = 1'b0;
    wr_addr    = ring(oldest_r, occ_r);
    rd_addr    = ring(oldest_r, idx_r);
    dreq.start    = 1'b0;
    dreq.dividend = in_index_roll;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pick_nxt = 1'b0;
          idx_nxt  = '0;
          if (!in_cmd) begin
            if (in_range_count == 64'd0) begin
              status_nxt = ST_IGNORED;
              state_nxt  = S_OUT;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (occ_r == '0 || {1'b0, in_chance_roll} >= rate) begin
            status_nxt = ST_NOPICK;
            state_nxt  = S_OUT;
          end else begin
            dreq.start = 1'b1;
            state_nxt  = S_DIV;
          end
        end
      end
      // rd_q holds the entry at idx_r - 1
      S_SCAN: begin
        if (idx_r != '0 && rd_q[191:128] == st_r && rd_q[127:64] == ct_r) begin
          status_nxt = ST_IGNORED;
          state_nxt  = S_OUT;
        end else if (idx_r == occ_r) begin
          status_nxt = ST_STORED;
          state_nxt  = S_OUT;
          wr_en      = 1'b1;
          if (occ_r == CW'(POOL_DEPTH)) begin
            wr_addr    = oldest_r;
            oldest_nxt = ring(oldest_r, CW'(1));
          end else begin
            occ_nxt = occ_r + CW'(1);
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_DIV: begin
        if (ddone) begin
          idx_nxt   = drem;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        status_nxt = ST_PICK;
        pick_nxt   = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {st_r, ct_r, ck_r};
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      oldest_r <= '0;
      occ_r    <= '0;
      idx_r    <= '0;
      status_r <= ST_STORED;
      pick_r   <= 1'b0;
      thr_r    <= 16'd32768;
      trust_r  <= 17'd3277;
      unprov_r <= 17'd16384;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      occ_r    <= occ_nxt;
      idx_r    <= idx_nxt;
      status_r <= status_nxt;
      pick_r   <= pick_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESH:  thr_r    <= cfg_data[15:0];
          CFG_TRUSTED: trust_r  <= cfg_data[16:0];
          CFG_UNPROV:  unprov_r <= cfg_data[16:0];
          default: ;
        endcase
      end
    end
    if (accept) begin
      st_r <= in_range_start;
      ct_r <= in_range_count;
      ck_r <= in_range_checksum;
    end
  end

  assign out_status        = status_r;
  assign out_pick_start    = pick_r ? rd_q[191:128] : 64'd0;
  assign out_pick_count    = pick_r ? rd_q[127:64]  : 64'd0;
  assign out_pick_checksum = pick_r ? rd_q[63:0]    : 64'd0;

`include "spot_check_range_pool_assert.svh"
  `SCRP_ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, occ_r <= CW'(POOL_DEPTH), "occupancy overflow")
  `SCRP_ASSERT_IMP(a_pick_status, clk, rst_n, out_valid && pick_r, out_status == ST_PICK, "pick status")
  `SCRP_ASSERT_NXT(a_rd_pick, clk, rst_n, state_r == S_RD, out_valid && pick_r, "pick not shown")
  `SCRP_ASSERT_IMP(a_no_cfg_busy, clk, rst_n, state_r != S_IDLE, !cfg_ready && !busy_in, "cfg while busy")
endmodule

### tb/tb_spot_check_range_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spot_check_range_pool
// Self-checking bench for the spot-check range pool: a directed table, then
// random remember and pick traffic under several register settings, with
// random gaps and stalls on both channels. Each result is checked against a
// behavioral model of the ring pool in the bench or a directed row's status.
// ----------------------------------------------------------------------------
module tb_spot_check_range_pool;
  import scrp_pkg::*;

  localparam int unsigned DEPTH = POOL_DEPTH_DEF;
  localparam logic [1:0] CFG_NONE = 2'd3;
  localparam bit CMD_REMEMBER = 1'b0;
  localparam bit CMD_PICK = 1'b1;

  typedef struct {
    bit          cmd;
    logic [63:0] start;
    logic [63:0] count;
    logic [63:0] sum;
    logic [15:0] score;
    logic [15:0] roll;
    logic [63:0] iroll;
  } range_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] start;
    logic [63:0] count;
    logic [63:0] sum;
  } pick_result_t;

  typedef struct {
    range_item_t it;
    bit          known;
    logic [1:0]  status;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = 1'b0;
  logic [63:0] in_range_start = '0;
  logic [63:0] in_range_count = '0;
  logic [63:0] in_range_checksum = '0;
  logic [15:0] in_worker_score = '0;
  logic [15:0] in_chance_roll = '0;
  logic [63:0] in_index_roll = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [63:0] out_pick_start;
  logic [63:0] out_pick_count;
  logic [63:0] out_pick_checksum;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  spot_check_range_pool dut (.*);

  always #2 clk = ~clk;

  // model state
  logic [63:0] pool_start [DEPTH];
  logic [63:0] pool_count [DEPTH];
  logic [63:0] pool_sum [DEPTH];
  int unsigned pool_oldest;
  int unsigned pool_used;
  logic [15:0] thresh_reg;
  logic [16:0] trusted_reg;
  logic [16:0] unproven_reg;

  pick_result_t expected_results[$];
  int errors = 0;
  bit idle_on = 1'b1;
  logic [63:0] start_set [8];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic pick_result_t predict_pool(input range_item_t it);
    pick_result_t r;
    int unsigned slot;
    logic [16:0] rate;
    r = '{ST_NOPICK, '0, '0, '0};
    if (it.cmd == CMD_REMEMBER) begin
      r.status = ST_STORED;
      if (it.count == 0) return '{ST_IGNORED, '0, '0, '0};
      for (int unsigned i = 0; i < pool_used; i++) begin
        slot = (pool_oldest + i) % DEPTH;
        if (pool_start[slot] == it.start && pool_count[slot] == it.count)
          return '{ST_IGNORED, '0, '0, '0};
      end
      if (pool_used >= DEPTH) begin
        slot = pool_oldest;
        pool_oldest = (pool_oldest + 1) % DEPTH;
      end else begin
        slot = (pool_oldest + pool_used) % DEPTH;
        pool_used++;
      end
      pool_start[slot] = it.start;
      pool_count[slot] = it.count;
      pool_sum[slot] = it.sum;
    end else if (pool_used != 0) begin
      rate = (it.score >= thresh_reg) ? trusted_reg : unproven_reg;
      if ({1'b0, it.roll} < rate) begin
        slot = (pool_oldest + int'(it.iroll % 64'(pool_used))) % DEPTH;
        r = '{ST_PICK, pool_start[slot], pool_count[slot], pool_sum[slot]};
      end
    end
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_THRESH:  thresh_reg = val[15:0];
      CFG_TRUSTED: trusted_reg = val[16:0];
      CFG_UNPROV:  unproven_reg = val[16:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait out all results before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send(input range_item_t it, input bit known, input logic [1:0] st);
    int gap;
    pick_result_t r;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= it.cmd;
    in_range_start <= it.start;
    in_range_count <= it.count;
    in_range_checksum <= it.sum;
    in_worker_score <= it.score;
    in_chance_roll <= it.roll;
    in_index_roll <= it.iroll;
    do @(posedge clk); while (in_stall);
    r = predict_pool(it);
    if (known) r = '{st, '0, '0, '0};
    expected_results.insert(expected_results.size(), r);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic range_item_t random_item();
    range_item_t it;
    int k;
    it.cmd = ($urandom_range(0, 99) < 55) ? CMD_REMEMBER : CMD_PICK;
    k = $urandom_range(0, 9);
    it.start = (k < 6) ? start_set[$urandom_range(0, 7)] + 64'($urandom_range(0, 40))
                       : rand64();
    k = $urandom_range(0, 19);
    it.count = (k == 0) ? 64'd0 : (k < 14) ? 64'($urandom_range(1, 4)) : rand64();
    it.sum = rand64();
    it.score = 16'($urandom);
    it.roll = 16'($urandom);
    it.iroll = rand64();
    return it;
  endfunction

  // result side: random stall per transfer, then check
  initial begin
    int n;
    forever begin
      n = idle_on ? $urandom_range(0, 6) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rst_n && out_valid));
      if (expected_results.size() == 0) begin
        report("result with nothing expected");
      end else begin
        pick_result_t e;
        e = expected_results.pop_front();
        if (out_status !== e.status)
          report($sformatf("status %0d, want %0d", out_status, e.status));
        if (out_pick_start !== e.start)
          report($sformatf("pick_start %h, want %h", out_pick_start, e.start));
        if (out_pick_count !== e.count)
          report($sformatf("pick_count %h, want %h", out_pick_count, e.count));
        if (out_pick_checksum !== e.sum)
          report($sformatf("pick_checksum %h, want %h", out_pick_checksum, e.sum));
      end
    end
  end

  initial begin
    #12_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    table_row_t rows[20];
    logic [63:0] ones;
    range_item_t it;
    ones = '1;
    for (int i = 0; i < DEPTH; i++) begin
      pool_start[i] = '0;
      pool_count[i] = '0;
      pool_sum[i] = '0;
    end
    pool_oldest = 0;
    pool_used = 0;
    thresh_reg = 16'd32768;
    trusted_reg = 17'd3277;
    unproven_reg = 17'd16384;
    for (int i = 0; i < 8; i++) start_set[i] = rand64();

    rows = '{
      '{'{CMD_PICK, 0, 0, 0, 16'hFFFF, 16'd0, 0}, 1, ST_NOPICK},
      '{'{CMD_REMEMBER, ones, 0, ones, 0, 0, 0}, 1, ST_IGNORED},
      '{'{CMD_REMEMBER, ones, ones, ones, 0, 0, 0}, 1, ST_STORED},
      '{'{CMD_REMEMBER, 0, 1, 0, 0, 0, 0}, 1, ST_STORED},
      '{'{CMD_REMEMBER, ones, ones, 64'h5, 0, 0, 0}, 1, ST_IGNORED},
      '{'{CMD_REMEMBER, 0, 1, ones, 16'hFFFF, 16'hFFFF, ones}, 1, ST_IGNORED},
      '{'{CMD_PICK, ones, ones, ones, 16'hFFFF, 16'd0, ones}, 0, 0},
      '{'{CMD_PICK, 0, 0, 0, 16'hFFFF, 16'd0, 0}, 0, 0},
      '{'{CMD_PICK, 0, 0, 0, 16'd0, 16'hFFFF, ones}, 1, ST_NOPICK},
      '{'{CMD_PICK, 0, 0, 0, 16'd32768, 16'd3276, 64'd1}, 0, 0},
      '{'{CMD_PICK, 0, 0, 0, 16'd32768, 16'd3277, 64'd1}, 1, ST_NOPICK},
      '{'{CMD_PICK, 0, 0, 0, 16'd32767, 16'd16383, 64'd3}, 0, 0},
      '{'{CMD_PICK, 0, 0, 0, 16'd32767, 16'd16384, 64'd3}, 1, ST_NOPICK},
      '{'{CMD_REMEMBER, 64'd7, 64'd9, 64'hA5A5, 0, 0, 0}, 1, ST_STORED},
      '{'{CMD_REMEMBER, 64'd7, 64'd10, 64'h5A5A, 0, 0, 0}, 1, ST_STORED},
      '{'{CMD_REMEMBER, 64'd8, 64'd9, 64'h0, 0, 0, 0}, 1, ST_STORED},
      '{'{CMD_PICK, 0, 0, 0, 16'd0, 16'd0, ones}, 0, 0},
      '{'{CMD_PICK, 0, 0, 0, 16'd0, 16'd0, 64'd2}, 0, 0},
      '{'{CMD_PICK, ones, ones, ones, 16'd0, 16'd100, 64'd4}, 0, 0},
      '{'{CMD_PICK, 0, 0, 0, 16'd65535, 16'd65535, 64'd0}, 1, ST_NOPICK}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].it, rows[i].known, rows[i].status);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_THRESH, 32'd0);
          write_reg(CFG_TRUSTED, 32'd65536);
          write_reg(CFG_UNPROV, 32'd0);
        end
        1: begin
          write_reg(CFG_THRESH, 32'hFFFF_FFFF);
          write_reg(CFG_TRUSTED, 32'd0);
          write_reg(CFG_UNPROV, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(CFG_NONE, 32'd0);
          write_reg(CFG_THRESH, 32'd65535);
          write_reg(CFG_UNPROV, 32'd65535);
        end
        default: begin
          write_reg(CFG_THRESH, $urandom);
          write_reg(CFG_TRUSTED, $urandom_range(0, 70000));
          write_reg(CFG_UNPROV, $urandom_range(0, 70000));
          write_reg(CFG_NONE, $urandom);
        end
      endcase
      for (int n = 0; n < 275; n++) begin
        if (n % 60 == 0) idle_on = ($urandom_range(0, 3) != 0);
        it = random_item();
        send(it, 1'b0, 2'd0);
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+src
src/scrp_pkg.sv
src/scrp_mod.sv
src/spot_check_range_pool.sv
tb/tb_spot_check_range_pool.sv
